@@ sv/cism_pkg.sv @@
// Package for the case-insensitive substring matcher.
// Holds the pattern size, beat codes, case folding and the cell control struct.
// No dependencies.
package cism_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);
  localparam int unsigned PosW       = 16;
  localparam int unsigned CountW     = 16;
  localparam int unsigned SymW       = 8;
  localparam int unsigned ActW       = 2;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2
  } action_e;

  // Broadcast from the top level to every cell for one accepted beat.
  typedef struct packed {
    logic            clear;
    logic            append;
    logic            text;
    logic [SymW-1:0] sym;
  } cell_ctrl_t;

  // Item held between the cell row and the output register.
  typedef struct packed {
    logic            valid;
    logic            clr;
    logic            hit;
    logic [PosW-1:0] start;
  } stage_t;

  // Map A..Z to a..z, leave every other byte as is.
  function automatic logic [SymW-1:0] fold_case(input logic [SymW-1:0] c);
    logic [SymW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

endpackage

@@ sv/cism_cell.sv @@
// One cell of the shift-and row: a pattern byte, its valid flag and one
// partial-match bit. Depends on cism_pkg.
module cism_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cism_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        prev_bit_i,
  input  logic                        prev_valid_i,
  input  logic                        next_valid_i,
  output logic                        bit_o,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic                        last_o
);

  logic [cism_pkg::SymW-1:0] pat_q, pat_d;
  logic                      valid_q, valid_d;
  logic                      bit_q, bit_d;
  logic                      hit_q, hit_d;
  logic                      is_last;
  logic                      new_bit;

  assign is_last = valid_q & ~next_valid_i;
  assign new_bit = prev_bit_i & (pat_q == ctrl_i.sym);

  always_comb begin
    pat_d   = pat_q;
    valid_d = valid_q;
    bit_d   = bit_q;
    hit_d   = 1'b0;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      bit_d   = 1'b0;
    end else if (ctrl_i.append) begin
      // take the byte only if this is the first empty slot
      if (!valid_q && prev_valid_i) begin
        pat_d   = ctrl_i.sym;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.text) begin
      if (valid_q) begin
        bit_d = new_bit;
        hit_d = new_bit & is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bit_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else if (ctrl_i.clear || ctrl_i.append || ctrl_i.text) begin
      valid_q <= valid_d;
      bit_q   <= bit_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  assign bit_o   = bit_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign last_o  = is_last;

endmodule

@@ sv/cism_result.sv @@
// Output stage: match counter and the registered result beat.
// Depends on cism_pkg.
module cism_result (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cism_pkg::stage_t               stage_i,
  output logic                           consume_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [cism_pkg::PosW+cism_pkg::CountW-1:0] m_axis_tdata_o
);

  logic                        out_valid_q, out_valid_d;
  logic [cism_pkg::PosW-1:0]   out_start_q, out_start_d;
  logic [cism_pkg::CountW-1:0] out_count_q, out_count_d;
  logic [cism_pkg::CountW-1:0] count_q, count_d;
  logic                        slot_free;
  logic                        consume;

  assign slot_free = ~out_valid_q | m_axis_tready_i;
  assign consume   = stage_i.valid & (~stage_i.hit | slot_free);

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_start_d = out_start_q;
    out_count_d = out_count_q;
    if (consume) begin
      if (stage_i.clr) begin
        count_d = '0;
      end else if (stage_i.hit) begin
        if (count_q != {cism_pkg::CountW{1'b1}}) begin
          count_d = count_q + 1'b1;
        end
        out_valid_d = 1'b1;
        out_start_d = stage_i.start;
        out_count_d = count_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_q <= out_start_d;
    out_count_q <= out_count_d;
  end

  assign consume_o       = consume;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_start_q};

endmodule

@@ sv/case_insensitive_substring_matcher_unit.sv @@
// Top level of the case-insensitive substring matcher: a row of shift-and
// cells, a hold stage and the output register.
// Depends on cism_pkg, cism_cell and cism_result.
//
//  channel  | dir | tdata fields (low bit up)              | beat means
//  ---------+-----+----------------------------------------+------------------------
//  s_axis   | in  | action[1:0], symbol[9:2], zero[15:10]  | clear, append or text
//  m_axis   | out | match_start[15:0], match_count[31:16]  | one completed match
//
// Flow: one beat per cycle in while s_axis_tready_o is high, one result per cycle
//   out while m_axis_tready_i is high; a completing text beat passes the hold stage
//   and output register. The cell row sets the rate; it updates every cell at once.
// Stalls: a stalled result holds in the output register while the next beat
//   still enters the cell row; the input stalls only when a second result
//   waits behind the held one.
// Reset: clears the cells' valid and match bits, length, position, count and the
//   hold-stage and output valid flags; pattern bytes are not reset.
module case_insensitive_substring_matcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // action[1:0], symbol[9:2], zero pad[15:10]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // match_start[15:0], match_count[31:16]
);

  localparam int unsigned Max = cism_pkg::MaxPattern;

  // Unpack the input beat.
  logic [cism_pkg::ActW-1:0] action;
  logic [cism_pkg::SymW-1:0] symbol;
  logic                      s_accept;
  assign action   = s_axis_tdata_i[cism_pkg::ActW-1:0];
  assign symbol   = s_axis_tdata_i[cism_pkg::ActW+cism_pkg::SymW-1:cism_pkg::ActW];
  assign s_accept = s_axis_tvalid_i & s_axis_tready_o;

  // Decode the beat into the broadcast to the cells. Unused action code drops.
  cism_pkg::cell_ctrl_t ctrl;
  always_comb begin
    ctrl.clear  = 1'b0;
    ctrl.append = 1'b0;
    ctrl.text   = 1'b0;
    ctrl.sym    = cism_pkg::fold_case(symbol);
    if (s_accept) begin
      case (action)
        cism_pkg::ACT_CLEAR:  ctrl.clear  = 1'b1;
        cism_pkg::ACT_APPEND: ctrl.append = 1'b1;
        cism_pkg::ACT_TEXT:   ctrl.text   = 1'b1;
        default: ;
      endcase
    end
  end

  // Cell row. Cell zero sees a constant one from the left (empty prefix
  // always matches, and slot zero is the first free one whenever it is empty).
  logic [Max-1:0] bit_w, valid_w, hit_w, last_w;
  logic [Max:0]   bit_ext, valid_ext, vnext_ext;
  assign bit_ext   = {bit_w, 1'b1};
  assign valid_ext = {valid_w, 1'b1};
  assign vnext_ext = {1'b0, valid_w};

  for (genvar k = 0; k < Max; k++) begin : g_cell
    cism_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_bit_i   (bit_ext[k]),
      .prev_valid_i (valid_ext[k]),
      .next_valid_i (vnext_ext[k+1]),
      .bit_o        (bit_w[k]),
      .valid_o      (valid_w[k]),
      .hit_o        (hit_w[k]),
      .last_o       (last_w[k])
    );
  end

  // Pattern length and text position; the hold stage keeps the start.
  logic [cism_pkg::LenW-1:0] len_q, len_d;
  logic [cism_pkg::PosW-1:0] pos_q, pos_d;
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_clr_q, s1_clr_d;
  logic [cism_pkg::PosW-1:0] s1_start_q, s1_start_d;
  logic [cism_pkg::PosW-1:0] len_ext;
  logic                      consume;
  cism_pkg::stage_t          stage;

  assign len_ext = cism_pkg::PosW'(len_q);

  // Accept whenever the hold stage is empty or drains this cycle.
  assign s_axis_tready_o = ~s1_valid_q | consume;

  // Only beats that reach the cells enter the hold stage; an unused code
  // is taken and dropped, since the cells' hit flags stay from the last beat.
  always_comb begin
    len_d      = len_q;
    pos_d      = pos_q;
    s1_valid_d = s1_valid_q & ~consume;
    s1_clr_d   = s1_clr_q;
    s1_start_d = s1_start_q;
    if (ctrl.clear || ctrl.append || ctrl.text) begin
      s1_valid_d = 1'b1;
      s1_clr_d   = ctrl.clear;
      s1_start_d = pos_q - len_ext + 1'b1;
      if (ctrl.clear) begin
        len_d = '0;
        pos_d = '0;
      end else if (ctrl.append) begin
        if (len_q != cism_pkg::LenW'(Max)) begin
          len_d = len_q + 1'b1;
        end
      end else if (ctrl.text) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_clr_q   <= 1'b0;
    end else begin
      len_q      <= len_d;
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
      s1_clr_q   <= s1_clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_start_q <= s1_start_d;
  end

  // At most one cell flags a hit (the last valid one), so OR the row.
  assign stage.valid = s1_valid_q;
  assign stage.clr   = s1_clr_q;
  assign stage.hit   = |hit_w;
  assign stage.start = s1_start_q;

  cism_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .consume_o       (consume),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Checks on the cell row and its bookkeeping.
  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(last_w))
    else $error("more than one cell marked as pattern end");

  a_len_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(len_q))
    else $error("pattern length disagrees with valid cells");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= cism_pkg::LenW'(Max))
    else $error("pattern length beyond maximum");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (len_q == '0 && pos_q == '0 && hit_w == '0))
    else $error("clear beat left state behind");

  a_hit_needs_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|hit_w) |-> (len_q != '0))
    else $error("match flagged with empty pattern");

endmodule
